>>> hdl/clr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clr_pkg
// Shared constants, state type and controller/datapath interface structs
// for the clipped line rasterizer.
// ---------------------------------------------------------------------------
package clr_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // datapath widths
    localparam int COORD_W = 16;   // endpoint coordinates
    localparam int DELTA_W = 17;   // signed endpoint differences
    localparam int DMAG_W  = 16;   // magnitude of the stepped difference
    localparam int PROD_W  = 34;   // one product term of the numerator
    localparam int NUM_W   = 35;   // signed numerator and floor quotient
    localparam int MAG_W   = 34;   // numerator magnitude, divider dividend
    localparam int SIZE_W  = 7;    // clamped range bounds, 0..64
    localparam int PIX_W   = 6;    // pixel row and column
    localparam int COLOR_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_SUM,
        S_DSTART,
        S_DWAIT,
        S_FIX,
        S_RUN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;       // capture line command and frame size
        logic setup;      // deltas, direction and clamped range
        logic mul;        // numerator product terms
        logic sum;        // numerator and sign normalisation
        logic div_start;  // launch the divider
        logic fix;        // floor quotient and remainder
        logic step;       // one stepped coordinate
        logic flush;      // release the held pixel as the last one
    } t_cmd;

    typedef struct packed {
        logic empty;      // no stepped coordinate in range
        logic div_done;   // divider result ready
        logic run_end;    // current coordinate is the final one
        logic can_push;   // output register can take a word
    } t_stat;

    // clamp a signed coordinate into [0, size]
    function automatic logic [SIZE_W-1:0] clamp_coord(
        input logic signed [COORD_W-1:0] v,
        input logic        [SIZE_W-1:0]  size
    );
        logic signed [COORD_W-1:0] lim;
        lim = $signed({{(COORD_W-SIZE_W){1'b0}}, size});
        if (v < 0)
            return '0;
        else if (v > lim)
            return size;
        else
            return v[SIZE_W-1:0];
    endfunction

    // saturate a frame size register to its maximum
    function automatic logic [SIZE_W-1:0] sat_size(
        input logic [CFG_DATA_W-1:0] v,
        input logic [SIZE_W-1:0]     max_v
    );
        return (v > max_v) ? max_v : v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/clipped_line_rasterizer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clipped_line_rasterizer
// Line command in, clipped framebuffer pixel writes out, last one flagged.
// ---------------------------------------------------------------------------
// sequence: setup (SETUP, MUL, SUM and DSTART states), divider run, fixup, then one
//   stepped coordinate per cycle over the clamped range while the output can take a word, flush
// an empty range returns to idle from MUL; a new line is taken only when idle, so one
//   line is in flight at a time; output stalls hold the stepping loop
// reset: synchronous active low, frame width and height return to 64,
//   sequencer idle and no pixel word pending
module clipped_line_rasterizer (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration channel
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [clr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [clr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // line command channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire signed [clr_pkg::COORD_W-1:0] i_start_x,
    input  wire signed [clr_pkg::COORD_W-1:0] i_start_y,
    input  wire signed [clr_pkg::COORD_W-1:0] i_end_x,
    input  wire signed [clr_pkg::COORD_W-1:0] i_end_y,
    input  wire [clr_pkg::COLOR_W-1:0]        i_line_color,
    // pixel write channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [clr_pkg::PIX_W-1:0]         o_pixel_row,
    output logic [clr_pkg::PIX_W-1:0]         o_pixel_col,
    output logic [clr_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                              o_last_pixel
);
    import clr_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;

    clr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (busy),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    clr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_line_color  (i_line_color),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_col   (o_pixel_col),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
`default_nettype wire

>>> hdl/clr_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module clr_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [clr_pkg::MAG_W-1:0]     i_dividend,
    input  wire [clr_pkg::DMAG_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [clr_pkg::MAG_W-1:0]    o_quotient,
    output logic [clr_pkg::DMAG_W-1:0]   o_remainder
);
    import clr_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_dvd, n_dvd;
    logic [DMAG_W-1:0] r_rem, n_rem;
    logic [DMAG_W-1:0] r_dsr;

    logic [DMAG_W:0]   trial;
    logic [DMAG_W:0]   diff;
    logic              qbit;

    // one shift-subtract step
    always_comb begin
        trial = {r_rem, r_dvd[MAG_W-1]};
        diff  = trial - {1'b0, r_dsr};
        qbit  = (trial >= {1'b0, r_dsr});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[MAG_W-2:0], qbit};
            n_rem = qbit ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_start)
            r_dsr <= i_divisor;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

>>> hdl/clr_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clr_dp
// Rasterizer datapath: frame size registers, line setup, numerator,
// incremental quotient stepping, held pixel and output register.
// ---------------------------------------------------------------------------
module clr_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  clr_pkg::t_cmd                     i_cmd,
    output clr_pkg::t_stat                    o_stat,
    // configuration writes
    input  wire                               i_cfg_we,
    input  wire [clr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [clr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // line command
    input  wire signed [clr_pkg::COORD_W-1:0] i_start_x,
    input  wire signed [clr_pkg::COORD_W-1:0] i_start_y,
    input  wire signed [clr_pkg::COORD_W-1:0] i_end_x,
    input  wire signed [clr_pkg::COORD_W-1:0] i_end_y,
    input  wire [clr_pkg::COLOR_W-1:0]        i_line_color,
    // pixel writes
    input  wire                               i_out_stall,
    output logic                              o_out_valid,
    output logic [clr_pkg::PIX_W-1:0]         o_pixel_row,
    output logic [clr_pkg::PIX_W-1:0]         o_pixel_col,
    output logic [clr_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                              o_last_pixel
);
    import clr_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_HEIGHT);

    // unit step of the quotient
    localparam logic signed [NUM_W-1:0] Q_ONE = NUM_W'(1);

    // frame size registers
    logic [CFG_DATA_W-1:0] r_frame_w, r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= CFG_DATA_W'(MAX_WIDTH);
            r_frame_h <= CFG_DATA_W'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FRAME_WIDTH)
                r_frame_w <= i_cfg_data;
            else if (i_cfg_index == CFG_FRAME_HEIGHT)
                r_frame_h <= i_cfg_data;
        end
    end

    // captured command
    logic signed [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [COLOR_W-1:0]        r_color;
    logic [SIZE_W-1:0]         r_w, r_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1    <= i_start_x;
            r_y1    <= i_start_y;
            r_x2    <= i_end_x;
            r_y2    <= i_end_y;
            r_color <= i_line_color;
            r_w     <= sat_size(r_frame_w, MAX_W);
            r_h     <= sat_size(r_frame_h, MAX_H);
        end
    end

    // setup: deltas, direction and clamped stepped range
    logic signed [DELTA_W-1:0] dx, dy, adx, ady;
    logic                      steep;
    logic signed [COORD_W-1:0] s_min, s_max;
    logic [SIZE_W-1:0]         s_size;

    always_comb begin
        dx    = $signed({r_x2[COORD_W-1], r_x2}) - $signed({r_x1[COORD_W-1], r_x1});
        dy    = $signed({r_y2[COORD_W-1], r_y2}) - $signed({r_y1[COORD_W-1], r_y1});
        adx   = dx[DELTA_W-1] ? -dx : dx;
        ady   = dy[DELTA_W-1] ? -dy : dy;
        steep = (ady > adx);
        if (steep) begin
            s_min  = (r_y1 < r_y2) ? r_y1 : r_y2;
            s_max  = (r_y1 < r_y2) ? r_y2 : r_y1;
            s_size = r_h;
        end else begin
            s_min  = (r_x1 < r_x2) ? r_x1 : r_x2;
            s_max  = (r_x1 < r_x2) ? r_x2 : r_x1;
            s_size = r_w;
        end
    end

    logic signed [DELTA_W-1:0] r_ds, r_do;
    logic signed [COORD_W-1:0] r_a1, r_o1;
    logic [SIZE_W-1:0]         r_lo, r_hi, r_lim;
    logic                      r_steep, r_zero;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_steep <= steep;
            r_zero  <= (dx == '0) && (dy == '0);
            r_ds    <= steep ? dy : dx;
            r_do    <= steep ? dx : dy;
            r_a1    <= steep ? r_y1 : r_x1;
            r_o1    <= steep ? r_x1 : r_y1;
            r_lo    <= clamp_coord(s_min, s_size);
            r_hi    <= clamp_coord(s_max, s_size);
            r_lim   <= steep ? r_w : r_h;
        end
    end

    // numerator product terms
    logic signed [DELTA_W-1:0] off;
    logic signed [PROD_W-1:0]  p1, p2;
    logic signed [PROD_W-1:0]  r_p1, r_p2;

    always_comb begin
        off = $signed({{(DELTA_W-SIZE_W){1'b0}}, r_lo})
            - $signed({r_a1[COORD_W-1], r_a1});
        p1  = PROD_W'(off * r_do);
        p2  = PROD_W'(r_o1 * r_ds);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1 <= p1;
            r_p2 <= p2;
        end
    end

    // numerator normalised to a positive divisor
    logic signed [NUM_W-1:0]   num, nrm, nmag;
    logic                      r_neg;
    logic [MAG_W-1:0]          r_mag;
    logic [DMAG_W-1:0]         r_dmag;
    logic signed [DELTA_W-1:0] r_e;
    logic signed [DELTA_W-1:0] dsmag;

    always_comb begin
        num   = $signed({r_p1[PROD_W-1], r_p1}) + $signed({r_p2[PROD_W-1], r_p2});
        nrm   = r_ds[DELTA_W-1] ? -num : num;
        nmag  = nrm[NUM_W-1] ? -nrm : nrm;
        dsmag = r_ds[DELTA_W-1] ? -r_ds : r_ds;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_neg  <= nrm[NUM_W-1];
            r_mag  <= nmag[MAG_W-1:0];
            r_dmag <= dsmag[DMAG_W-1:0];
            r_e    <= r_ds[DELTA_W-1] ? -r_do : r_do;
        end
    end

    // divider
    logic              div_done;
    logic [MAG_W-1:0]  div_q;
    logic [DMAG_W-1:0] div_r;

    clr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_dmag),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // floor quotient and remainder, then incremental stepping
    logic signed [NUM_W-1:0] r_qf;
    logic [DMAG_W-1:0]       r_r;
    logic [SIZE_W-1:0]       r_s;
    logic signed [NUM_W-1:0] qa_s;

    logic signed [NUM_W-1:0] cand_q;
    logic                    cand_ok;
    logic signed [DMAG_W+1:0] t_r;
    logic signed [DMAG_W+1:0] dm_s;

    always_comb begin
        qa_s    = $signed({1'b0, div_q});
        cand_q  = (r_qf[NUM_W-1] && (r_r != '0)) ? r_qf + Q_ONE : r_qf;
        cand_ok = !cand_q[NUM_W-1]
               && (cand_q < $signed({{(NUM_W-SIZE_W){1'b0}}, r_lim}));
        dm_s    = $signed({2'b00, r_dmag});
        t_r     = $signed({2'b00, r_r}) + $signed({r_e[DELTA_W-1], r_e});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_s <= r_lo;
            if (r_neg && (div_r != '0)) begin
                r_qf <= -qa_s - Q_ONE;
                r_r  <= r_dmag - div_r;
            end else begin
                r_qf <= r_neg ? -qa_s : qa_s;
                r_r  <= r_neg ? '0 : div_r;
            end
        end else if (i_cmd.step) begin
            r_s <= r_s + 1'b1;
            if (t_r >= dm_s) begin
                r_r  <= DMAG_W'(t_r - dm_s);
                r_qf <= r_qf + Q_ONE;
            end else if (t_r < 0) begin
                r_r  <= DMAG_W'(t_r + dm_s);
                r_qf <= r_qf - Q_ONE;
            end else begin
                r_r  <= DMAG_W'(t_r);
            end
        end
    end

    // held pixel, released once the next one is known
    logic             r_pend_valid;
    logic [PIX_W-1:0] r_pend_row, r_pend_col;
    logic [PIX_W-1:0] cand_row, cand_col;
    logic             can_push, push_word, take_cand;

    always_comb begin
        cand_row  = r_steep ? r_s[PIX_W-1:0] : cand_q[PIX_W-1:0];
        cand_col  = r_steep ? cand_q[PIX_W-1:0] : r_s[PIX_W-1:0];
        can_push  = !o_out_valid || !i_out_stall;
        take_cand = i_cmd.step && cand_ok;
        push_word = r_pend_valid && (take_cand || i_cmd.flush);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (take_cand) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_cand) begin
            r_pend_row <= cand_row;
            r_pend_col <= cand_col;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (can_push) begin
            o_out_valid <= push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_push && push_word) begin
            o_pixel_row   <= r_pend_row;
            o_pixel_col   <= r_pend_col;
            o_pixel_color <= r_color;
            o_last_pixel  <= i_cmd.flush;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.empty    = r_zero || (r_lo >= r_hi);
        o_stat.div_done = div_done;
        o_stat.run_end  = (r_s == r_hi - 1'b1);
        o_stat.can_push = can_push;
    end

endmodule
`default_nettype wire

>>> hdl/clr_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clr_ctrl
// Rasterizer sequencer: setup, division, stepping and final flush.
// ---------------------------------------------------------------------------
module clr_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_busy,
    input  clr_pkg::t_stat  i_stat,
    output clr_pkg::t_cmd   o_cmd
);
    import clr_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                if (i_stat.empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done)
                    n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_RUN;
            end
            S_RUN: begin
                if (i_stat.can_push) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.run_end)
                        n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.can_push) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire
